### src/hbht_pkg.sv
// Package for the huge block hash table: sizes, codes, register addresses.
// No dependencies.
package hbht_pkg;
	localparam int TABLE_BITS = 10;
	localparam int CELL_SHIFT = 4;
	localparam int NSLOTS = 1 << TABLE_BITS;
	localparam int KEY_W = 47;
	localparam int SIZE_W = 48;
	localparam int FLAG_W = 4;

	typedef logic [TABLE_BITS-1:0] slot_t;
	typedef logic [KEY_W-1:0] key_t;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_MARK = 2'd2;
	localparam logic [1:0] MODE_DELETE = 2'd3;

	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_PRESENT = 3'd1;
	localparam logic [2:0] ST_MISS = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam key_t KEY_EMPTY = '0;
	localparam key_t KEY_TOMB = key_t'(1);

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int MIX_SHIFT = 33;

	localparam logic [1:0] REG_INDEX_BITS = 2'd0;
	localparam logic [1:0] REG_HUGE_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_FLAG_MASK = 2'd2;
	localparam logic [1:0] REG_MARK_FLAG = 2'd3;

	// Command to the hash unit, status back
	typedef struct packed {
		logic start;
		logic [63:0] seed;
	} hash_req_t;
	typedef struct packed {
		logic done;
		logic [31:0] hash;
	} hash_rsp_t;
endpackage

### src/huge_block_hash_table.sv
// Top level of the huge block hash table: control, slot memories, APB registers.
// Depends on hbht_pkg and hbht_hash.
//
//  channel   handshake                 payload
//  command   start / busy              mode, address, block_size, flags_in
//  result    done (one-cycle strobe)   status, size_out, flags_out
//  config    APB psel/penable/pwrite   paddr, pwdata, prdata
//
// Sequence: an insert, lookup, mark or delete first hashes the address on the
// shared 32x32 multiplier, then probes slot by slot (a memory read in S_READ, a
// compare in S_CMP), passes through S_META on a hit and writes back in S_FIN;
// done rises the cycle after. An invalid insert, or a lookup, mark or delete of
// address 0 or 1, skips hashing, goes to S_BAD or S_FIN and reports in the next.
// Reset: a clearing pass writes every slot key empty, with busy high.
// Stalls: the receiver cannot stall; done lasts one cycle.
module huge_block_hash_table
	import hbht_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] mode,
	input logic [KEY_W-1:0] address,
	input logic [SIZE_W-1:0] block_size,
	input logic [FLAG_W-1:0] flags_in,
	output logic done,
	output logic [2:0] status,
	output logic [SIZE_W-1:0] size_out,
	output logic [FLAG_W-1:0] flags_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CMP = 3'd3;
	localparam logic [2:0] S_META = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;
	localparam logic [2:0] S_BAD = 3'd6;
	localparam logic [2:0] S_CLR = 3'd7;

	// Registers
	logic [3:0] index_bits_q;
	logic [KEY_W-1:0] thresh_q;
	logic [FLAG_W-1:0] fmask_q, mflag_q;

	assign pready = 1'b1;
	logic wr_en;
	assign wr_en = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= 4'd10;
			thresh_q <= KEY_W'(65536);
			fmask_q <= 4'hf;
			mflag_q <= 4'h1;
		end else if (wr_en) begin
			case (paddr[4:3])
				REG_INDEX_BITS: index_bits_q <= pwdata[3:0];
				REG_HUGE_THRESHOLD: thresh_q <= pwdata[KEY_W-1:0];
				REG_FLAG_MASK: fmask_q <= pwdata[3:0];
				REG_MARK_FLAG: mflag_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[4:3])
			REG_INDEX_BITS: prdata = {60'd0, index_bits_q};
			REG_HUGE_THRESHOLD: prdata = {17'd0, thresh_q};
			REG_FLAG_MASK: prdata = {60'd0, fmask_q};
			default: prdata = {60'd0, mflag_q};
		endcase
	end

	// Probe mask with index_bits saturated to the table size
	logic [3:0] ib_sat;
	slot_t pmask;
	assign ib_sat = (index_bits_q > 4'(TABLE_BITS)) ? 4'(TABLE_BITS) : index_bits_q;
	assign pmask = slot_t'((32'd1 << ib_sat) - 32'd1);

	// Command latch and sequencer
	logic [2:0] st_q;
	logic [1:0] mode_q;
	key_t addr_q;
	logic [SIZE_W-1:0] size_q;
	logic [FLAG_W-1:0] flags_q;
	slot_t idx_q, free_q;
	logic [TABLE_BITS:0] cnt_q;
	logic have_free_q, hit_q;
	logic accept;
	assign busy = (st_q != S_IDLE);
	assign accept = start && !busy;

	// Addresses 0 and 1 never match, and invalid inserts are refused: skip hashing and probing for them
	hash_req_t hreq;
	hash_rsp_t hrsp;
	assign hreq.start = accept && !(address <= KEY_TOMB || (mode == MODE_INSERT &&
		({1'b0, block_size} <= {2'b0, thresh_q}
		|| (flags_in & ~fmask_q) != '0)));
	assign hreq.seed = 64'(address >> CELL_SHIFT);
	hbht_hash u_hash (.clk(clk), .arst_n(arst_n), .req(hreq), .rsp(hrsp));

	// Slot memories; keys are cleared by a pass after reset
	key_t key_mem [NSLOTS];
	logic [SIZE_W+FLAG_W-1:0] meta_mem [NSLOTS];
	key_t key_rd_s1;
	logic [SIZE_W+FLAG_W-1:0] meta_rd_s1;
	key_t k;
	slot_t clr_q;
	assign k = key_rd_s1;

	logic kwe, mwe;
	slot_t kwa;
	key_t kwd;
	logic [SIZE_W+FLAG_W-1:0] mwd;

	always_ff @(posedge clk) begin
		key_rd_s1 <= key_mem[idx_q];
		meta_rd_s1 <= meta_mem[idx_q];
		if (kwe) key_mem[kwa] <= kwd;
		if (mwe) meta_mem[kwa] <= mwd;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (st_q == S_CLR) begin
			clr_q <= clr_q + slot_t'(1);
		end
	end

	// Write-back at the end of an item, and the clearing writes after reset
	logic [FLAG_W-1:0] old_fl, new_fl;
	assign old_fl = meta_rd_s1[FLAG_W-1:0];
	assign new_fl = old_fl | mflag_q;
	always_comb begin
		kwe = 1'b0; mwe = 1'b0; kwa = idx_q; kwd = addr_q; mwd = {size_q, flags_q};
		if (st_q == S_CLR) begin
			kwe = 1'b1; kwa = clr_q; kwd = KEY_EMPTY;
		end else if (st_q == S_FIN) begin
			case (mode_q)
				MODE_INSERT: if (!hit_q && have_free_q) begin
					kwe = 1'b1; mwe = 1'b1; kwa = free_q;
				end
				MODE_MARK: if (hit_q) begin
					mwe = 1'b1; mwd = {meta_rd_s1[SIZE_W+FLAG_W-1:FLAG_W], new_fl};
				end
				MODE_DELETE: if (hit_q) begin
					kwe = 1'b1; mwe = 1'b1; kwd = KEY_TOMB; mwd = '0;
				end
				default: ;
			endcase
		end
	end

	logic last;
	assign last = (cnt_q == {1'b0, pmask});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_CLR: if (clr_q == slot_t'(NSLOTS - 1)) st_q <= S_IDLE;
				S_IDLE: if (accept) st_q <= hreq.start ? S_HASH :
					(mode == MODE_INSERT ? S_BAD : S_FIN);
				S_HASH: if (hrsp.done) st_q <= S_READ;
				S_READ: st_q <= S_CMP;
				S_CMP: begin
					// advance to the next slot, or stop
					if (k == addr_q) st_q <= S_META;
					else if (k == KEY_EMPTY || last) st_q <= S_FIN;
					else st_q <= S_READ;
				end
				S_META: st_q <= S_FIN;
				S_FIN, S_BAD: begin st_q <= S_IDLE; done <= 1'b1; end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (accept) begin
				mode_q <= mode; addr_q <= address; size_q <= block_size; flags_q <= flags_in;
				have_free_q <= 1'b0; hit_q <= 1'b0; cnt_q <= '0;
			end
			S_HASH: idx_q <= slot_t'(hrsp.hash) & pmask;
			S_CMP: begin
				if (k == addr_q) hit_q <= 1'b1;
				else begin
					if ((k == KEY_EMPTY || k == KEY_TOMB) && !have_free_q) begin
						have_free_q <= 1'b1; free_q <= idx_q;
					end
					if (!(k == KEY_EMPTY || last)) begin
						idx_q <= (idx_q + slot_t'(1)) & pmask;
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
		// hold result payload
		if (st_q == S_BAD) begin
			status <= ST_INVALID; size_out <= '0; flags_out <= '0;
		end else if (st_q == S_FIN) begin
			size_out <= '0; flags_out <= '0;
			if (mode_q == MODE_INSERT)
				status <= hit_q ? ST_PRESENT : (have_free_q ? ST_DONE : ST_FULL);
			else if (!hit_q) status <= ST_MISS;
			else begin
				size_out <= meta_rd_s1[SIZE_W+FLAG_W-1:FLAG_W];
				flags_out <= (mode_q == MODE_MARK) ? new_fl : old_fl;
				status <= (mode_q == MODE_MARK && (old_fl & mflag_q) != '0)
					? ST_PRESENT : ST_DONE;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted item without going busy");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while still busy");
	a_hit_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(kwe && st_q == S_FIN && mode_q == MODE_DELETE) |-> hit_q)
		else $error("tombstone without hit");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CMP |-> cnt_q <= {1'b0, pmask}) else $error("probe ran past table");
`endif
endmodule

### src/hbht_hash.sv
// Murmur 64-bit finalizer, iterative over one shared 32x32 multiplier.
// Depends on hbht_pkg.
module hbht_hash
	import hbht_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input hash_req_t req,
	output hash_rsp_t rsp
);
	// Each 64x64 low product takes three partial products: lo*lo, lo*hi, hi*lo.
	localparam logic [3:0] H_IDLE = 4'd0;
	localparam logic [3:0] H_P0 = 4'd1;
	localparam logic [3:0] H_P1 = 4'd2;
	localparam logic [3:0] H_P2 = 4'd3;
	localparam logic [3:0] H_Q0 = 4'd4;
	localparam logic [3:0] H_Q1 = 4'd5;
	localparam logic [3:0] H_Q2 = 4'd6;
	localparam logic [3:0] H_FIN = 4'd7;

	logic [3:0] st_q;
	logic [63:0] x_q, acc_q, c;
	logic [31:0] ma, mb;
	logic [63:0] prod;
	logic [63:0] xs;

	assign xs = x_q ^ (x_q >> MIX_SHIFT);
	assign c = (st_q == H_Q0 || st_q == H_Q1 || st_q == H_Q2) ? MIX_C2 : MIX_C1;

	always_comb begin
		case (st_q)
			H_P0, H_Q0: begin ma = x_q[31:0]; mb = c[31:0]; end
			H_P1, H_Q1: begin ma = x_q[31:0]; mb = c[63:32]; end
			default: begin ma = x_q[63:32]; mb = c[31:0]; end
		endcase
	end
	assign prod = 64'(ma) * 64'(mb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
		end else begin
			case (st_q)
				H_IDLE: if (req.start) st_q <= H_P0;
				H_P0: st_q <= H_P1;
				H_P1: st_q <= H_P2;
				H_P2: st_q <= H_Q0;
				H_Q0: st_q <= H_Q1;
				H_Q1: st_q <= H_Q2;
				H_Q2: st_q <= H_FIN;
				default: st_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			H_IDLE: if (req.start) x_q <= req.seed ^ (req.seed >> MIX_SHIFT);
			H_P0, H_Q0: acc_q <= prod;
			H_P1, H_Q1: acc_q <= acc_q + {prod[31:0], 32'd0};
			// fold the xor-shift between the two multiplies
			H_P2: x_q <= (acc_q + {prod[31:0], 32'd0})
				^ ((acc_q + {prod[31:0], 32'd0}) >> MIX_SHIFT);
			H_Q2: x_q <= acc_q + {prod[31:0], 32'd0};
			default: ;
		endcase
	end

	assign rsp.done = (st_q == H_FIN);
	assign rsp.hash = xs[31:0];

`ifndef NO_ASSERTIONS
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == H_Q2 |=> rsp.done) else $error("hash sequence broken");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == H_IDLE && req.start) |=> st_q == H_P0) else $error("hash did not start");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> st_q == H_IDLE) else $error("hash did not finish");
`endif
endmodule

### sim/hbht_checker.sv
// Checker for the huge block hash table: watches command, result and APB channels,
// predicts each result from its own copy of the table and compares in order.
// Depends on hbht_pkg.
`timescale 1ns / 100ps
module hbht_checker
	import hbht_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [1:0] mode,
	input logic [KEY_W-1:0] address,
	input logic [SIZE_W-1:0] block_size,
	input logic [FLAG_W-1:0] flags_in,
	input logic done,
	input logic [2:0] status,
	input logic [SIZE_W-1:0] size_out,
	input logic [FLAG_W-1:0] flags_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [63:0] pwdata,
	input logic pready,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic [2:0] status;
		logic [SIZE_W-1:0] size;
		logic [FLAG_W-1:0] flags;
	} outcome_t;

	key_t tbl_key [NSLOTS];
	logic [SIZE_W-1:0] tbl_size [NSLOTS];
	logic [FLAG_W-1:0] tbl_flags [NSLOTS];

	logic [3:0] cfg_index_bits;
	logic [KEY_W-1:0] cfg_threshold;
	logic [FLAG_W-1:0] cfg_flag_mask;
	logic [FLAG_W-1:0] cfg_mark_flag;

	outcome_t outcome_q[$];

	function automatic logic [31:0] mix_hash(key_t a);
		logic [63:0] x;
		x = 64'(a) >> CELL_SHIFT;
		x ^= x >> MIX_SHIFT;
		x = x * MIX_C1;
		x ^= x >> MIX_SHIFT;
		x = x * MIX_C2;
		x ^= x >> MIX_SHIFT;
		return x[31:0];
	endfunction

	function automatic logic [31:0] slot_mask();
		int b;
		b = (cfg_index_bits > TABLE_BITS) ? TABLE_BITS : int'(cfg_index_bits);
		return (32'd1 << b) - 32'd1;
	endfunction

	// Apply one operation to the shadow table and return what the block should report.
	function automatic outcome_t apply_operation(logic [1:0] op, key_t a,
			logic [SIZE_W-1:0] sz, logic [FLAG_W-1:0] fl);
		outcome_t r;
		logic [31:0] m;
		logic [31:0] i;
		logic [31:0] fr;
		logic have_free;
		logic hit;
		r = '0;
		r.status = ST_MISS;
		m = slot_mask();
		i = mix_hash(a) & m;
		fr = '0;
		have_free = 1'b0;
		hit = 1'b0;
		if (op == MODE_INSERT) begin
			if (a <= KEY_TOMB || {1'b0, sz} <= {2'b0, cfg_threshold} ||
					(fl & ~cfg_flag_mask) != '0) begin
				r.status = ST_INVALID;
				return r;
			end
			for (longint n = 0; n <= longint'(m); n++) begin
				if (tbl_key[i] == a) begin
					hit = 1'b1;
					break;
				end
				if (tbl_key[i] == KEY_EMPTY || tbl_key[i] == KEY_TOMB) begin
					if (!have_free) begin
						have_free = 1'b1;
						fr = i;
					end
					if (tbl_key[i] == KEY_EMPTY)
						break;
				end
				i = (i + 1) & m;
			end
			if (hit)
				r.status = ST_PRESENT;
			else if (!have_free)
				r.status = ST_FULL;
			else begin
				tbl_key[fr] = a;
				tbl_size[fr] = sz;
				tbl_flags[fr] = fl;
				r.status = ST_DONE;
			end
			return r;
		end
		if (a <= KEY_TOMB)
			return r;
		for (longint n = 0; n <= longint'(m); n++) begin
			if (tbl_key[i] == KEY_EMPTY)
				break;
			if (tbl_key[i] == a) begin
				hit = 1'b1;
				break;
			end
			i = (i + 1) & m;
		end
		if (!hit)
			return r;
		r.size = tbl_size[i];
		r.flags = tbl_flags[i];
		r.status = ST_DONE;
		if (op == MODE_MARK) begin
			if ((r.flags & cfg_mark_flag) != '0)
				r.status = ST_PRESENT;
			r.flags = r.flags | cfg_mark_flag;
			tbl_flags[i] = r.flags;
		end else if (op == MODE_DELETE) begin
			tbl_key[i] = KEY_TOMB;
			tbl_size[i] = '0;
			tbl_flags[i] = '0;
		end
		return r;
	endfunction

	assign pending = outcome_q.size();

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			for (int k = 0; k < NSLOTS; k++) begin
				tbl_key[k] = KEY_EMPTY;
				tbl_size[k] = '0;
				tbl_flags[k] = '0;
			end
			cfg_index_bits = 4'd10;
			cfg_threshold = KEY_W'(65536);
			cfg_flag_mask = 4'hf;
			cfg_mark_flag = 4'h1;
			outcome_q.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				got = '{status, size_out, flags_out};
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						fail_count++;
					end
					if (got.size !== want.size) begin
						$display("%0t: size_out expected %h actual %h",
							$time, want.size, got.size);
						fail_count++;
					end
					if (got.flags !== want.flags) begin
						$display("%0t: flags_out expected %h actual %h",
							$time, want.flags, got.flags);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(apply_operation(mode, address, block_size, flags_in));
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_INDEX_BITS: cfg_index_bits = pwdata[3:0];
					REG_HUGE_THRESHOLD: cfg_threshold = pwdata[KEY_W-1:0];
					REG_FLAG_MASK: cfg_flag_mask = pwdata[3:0];
					REG_MARK_FLAG: cfg_mark_flag = pwdata[3:0];
					default: ;
				endcase
			end
		end
	end
endmodule

### sim/tb_huge_block_hash_table.sv
// Testbench top for the huge block hash table: clock, reset, APB setup and command stimulus.
// Depends on hbht_pkg, huge_block_hash_table and hbht_checker.
`timescale 1ns / 100ps
module tb_huge_block_hash_table;
	import hbht_pkg::*;

	localparam int CYCLE_LIMIT = 12000000;
	localparam int QUIET_TAIL = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = MODE_INSERT;
	logic [KEY_W-1:0] address = '0;
	logic [SIZE_W-1:0] block_size = '0;
	logic [FLAG_W-1:0] flags_in = '0;
	logic done;
	logic [2:0] status;
	logic [SIZE_W-1:0] size_out;
	logic [FLAG_W-1:0] flags_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	int cycles = 0;

	// Stimulus-side view of the settings, used only to shape inserts
	logic [KEY_W-1:0] cur_threshold = KEY_W'(65536);
	logic [FLAG_W-1:0] cur_flag_mask = 4'hf;
	key_t key_pool [16];
	int issued = 0;
	logic idling_on = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	huge_block_hash_table i_dut (.*);

	hbht_checker i_checker (.*);

	// Watchdog: end the run if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_huge_block_hash_table: errors");
			$finish;
		end
	end

	// APB write in setup and access phases; the register takes the value on the access edge
	task automatic reg_write(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_HUGE_THRESHOLD)
			cur_threshold = val[KEY_W-1:0];
		if (idx == REG_FLAG_MASK)
			cur_flag_mask = val[3:0];
	endtask

	// Hold off until every expected result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Present one command and hold it until the block takes the transfer
	task automatic send_op(logic [1:0] op, key_t a, logic [SIZE_W-1:0] sz,
			logic [FLAG_W-1:0] fl);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= op;
		address <= a;
		block_size <= sz;
		flags_in <= fl;
		do
			@(posedge clk);
		while (busy);
		issued++;
	endtask

	function automatic key_t rand_key();
		return {15'($urandom), $urandom};
	endfunction

	// New pool: four cells of four keys each, so keys in a cell share a home slot
	task automatic refill_pool();
		key_t base;
		for (int c = 0; c < 4; c++) begin
			base = rand_key() & ~key_t'(15);
			if (base <= KEY_TOMB)
				base = key_t'(32);
			for (int k = 0; k < 4; k++)
				key_pool[c*4+k] = base | key_t'($urandom_range(0, 15));
		end
	endtask

	// Mostly well-formed work on pooled keys, with some invalid and stray commands
	task automatic random_op();
		logic [1:0] op;
		key_t a;
		logic [SIZE_W-1:0] sz;
		logic [FLAG_W-1:0] fl;
		logic [SIZE_W-1:0] room;
		op = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 19))
			0: a = key_t'($urandom_range(0, 1));
			1, 2: a = rand_key();
			default: a = key_pool[$urandom_range(0, 15)];
		endcase
		room = {1'b1, {(SIZE_W-1){1'b1}}} - {1'b0, cur_threshold};
		if ($urandom_range(0, 9) == 0)
			sz = {16'($urandom), $urandom};
		else if ($urandom_range(0, 1) == 0)
			sz = {1'b0, cur_threshold} + 1 + SIZE_W'($urandom_range(0, 255));
		else
			sz = {1'b0, cur_threshold} + 1 + ({16'($urandom), $urandom} % room);
		if (sz <= {1'b0, cur_threshold} && $urandom_range(0, 1))
			sz = {1'b1, 47'($urandom)};
		fl = 4'($urandom);
		if ($urandom_range(0, 7) != 0)
			fl = fl & cur_flag_mask;
		send_op(op, a, sz, fl);
	endtask

	initial begin
		key_t k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: every register, field extremes, each special case
		reg_write(REG_INDEX_BITS, 64'd10);
		reg_write(REG_HUGE_THRESHOLD, 64'd65536);
		reg_write(REG_FLAG_MASK, 64'hf);
		reg_write(REG_MARK_FLAG, 64'h1);
		k = {KEY_W{1'b1}};
		send_op(MODE_INSERT, k, {SIZE_W{1'b1}}, 4'hf);
		send_op(MODE_INSERT, k, 48'd70000, 4'h0);
		send_op(MODE_INSERT, KEY_EMPTY, 48'd70000, 4'h0);
		send_op(MODE_INSERT, KEY_TOMB, 48'd70000, 4'h0);
		send_op(MODE_INSERT, key_t'(4096), 48'd65536, 4'h0);
		send_op(MODE_INSERT, key_t'(4096), 48'd65537, 4'h2);
		send_op(MODE_INSERT, key_t'(4097), 48'd65538, 4'h4);
		send_op(MODE_LOOKUP, k, 48'd0, 4'h0);
		send_op(MODE_LOOKUP, key_t'(4097), 48'd0, 4'h0);
		send_op(MODE_MARK, key_t'(4096), 48'd0, 4'h0);
		send_op(MODE_MARK, key_t'(4096), 48'd0, 4'h0);
		send_op(MODE_DELETE, key_t'(4096), 48'd0, 4'h0);
		send_op(MODE_LOOKUP, key_t'(4097), 48'd0, 4'h0);
		send_op(MODE_LOOKUP, key_t'(4096), 48'd0, 4'h0);
		send_op(MODE_INSERT, key_t'(4098), 48'd99999, 4'h1);
		send_op(MODE_LOOKUP, KEY_EMPTY, 48'd0, 4'h0);
		send_op(MODE_MARK, KEY_TOMB, 48'd0, 4'h0);
		send_op(MODE_DELETE, KEY_TOMB, 48'd0, 4'h0);
		drain();
		// Mark with an empty pattern, flags outside the mask, one-slot table filling up
		reg_write(REG_MARK_FLAG, 64'h0);
		reg_write(REG_FLAG_MASK, 64'h3);
		reg_write(REG_INDEX_BITS, 64'd0);
		send_op(MODE_MARK, key_t'(4097), 48'd0, 4'h0);
		send_op(MODE_INSERT, key_t'(8192), 48'd80000, 4'h4);
		send_op(MODE_INSERT, key_t'(8192), 48'd80000, 4'h3);
		send_op(MODE_INSERT, key_t'(12288), 48'd80000, 4'h1);
		send_op(MODE_DELETE, key_t'(8192), 48'd0, 4'h0);
		send_op(MODE_INSERT, key_t'(12288), 48'd80000, 4'h1);
		drain();

		// Random phases, each under its own settings, extremes included
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: reg_write(REG_INDEX_BITS, 64'd2);
				1: reg_write(REG_INDEX_BITS, 64'd15);
				2: reg_write(REG_INDEX_BITS, 64'd0);
				3: reg_write(REG_INDEX_BITS, 64'd1);
				default: reg_write(REG_INDEX_BITS, 64'($urandom_range(2, 5)));
			endcase
			case (ph)
				1: reg_write(REG_HUGE_THRESHOLD, 64'd0);
				4: reg_write(REG_HUGE_THRESHOLD, {17'd0, {KEY_W{1'b1}}});
				default: reg_write(REG_HUGE_THRESHOLD, 64'({15'($urandom), $urandom}));
			endcase
			reg_write(REG_FLAG_MASK, (ph == 2) ? 64'h0 : 64'($urandom_range(0, 15)));
			reg_write(REG_MARK_FLAG, (ph == 3) ? 64'hf : 64'($urandom_range(0, 15)));
			refill_pool();
			for (int n = 0; n < 100; n++) begin
				idling_on = (ph < 8) || (n < 100 - QUIET_TAIL + 100 - 50);
				random_op();
			end
			drain();
		end

		// All results in; let any trailing activity settle
		start <= 1'b0;
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb_huge_block_hash_table: clean");
		else
			$display("tb_huge_block_hash_table: errors");
		$finish;
	end
endmodule
